// ===== hw/rtl/shmc_pkg.sv =====
// Package for the shadow memory access checker.
// Holds the operation and fault codes, reset constants and the command and
// status structs between the controller and the datapath. No dependencies.
`default_nettype none

package shmc_pkg;

    localparam int unsigned SHADOW_BYTES_DEF = 65536;
    localparam logic [31:0] BASE_RESET       = 32'hC000_0000;

    typedef enum logic [1:0] {
        OP_CHECK    = 2'd0,
        OP_UNPOISON = 2'd1,
        OP_POISON   = 2'd2,
        OP_IGNORE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_BELOW    = 2'd1,
        KIND_POISONED = 2'd2,
        KIND_WINDOW   = 2'd3
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;
        logic  calc_rel;
        logic  calc_range;
        logic  calc_win;
        logic  step;
        logic  mem_we;
        logic  clr_sel;
        logic  out_load;
        t_kind kind;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic size_zero;
        logic below;
        logic win_bad;
        logic at_stop;
        logic bad_byte;
        logic partial;
        logic clr_last;
    } t_status;

endpackage

`default_nettype wire

// ===== hw/rtl/shmc_req_if.sv =====
// Request channel of the shadow memory access checker: valid/ready and the
// request fields. Depends on shmc_pkg for nothing but kept in the same order.
`default_nettype none

interface shmc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] addr;
    logic [23:0] size;
    logic [7:0]  poison_value;
    logic        wr_access;

    modport source (output valid, op, addr, size, poison_value, wr_access, input ready);
    modport sink   (input valid, op, addr, size, poison_value, wr_access, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/shmc_rsp_if.sv =====
// Result channel of the shadow memory access checker: valid/ready and the
// report fields. No dependencies.
`default_nettype none

interface shmc_rsp_if;
    logic        valid;
    logic        ready;
    logic        fault;
    logic [1:0]  fault_kind;
    logic [31:0] report_addr;
    logic [23:0] report_size;
    logic        report_write;

    modport source (output valid, fault, fault_kind, report_addr, report_size, report_write,
                    input ready);
    modport sink   (input valid, fault, fault_kind, report_addr, report_size, report_write,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/shadow_memory_access_checker_core.sv =====
// Shadow memory access checker, top level.
// Each request on i_req is a check, an unpoison or a poison of a byte range,
// or an ignored op; each yields exactly one result on o_rsp (fault flag, kind
// and echo of the offending request, all zero when there is no fault).
// The single configuration register, the region base, is written through
// i_cfg_we / i_cfg_wdata while no request is in progress; the user must
// keep to this, as the block does not enforce it. After reset the shadow
// RAM is cleared one granule per cycle; i_req.ready stays low until that
// pass is complete. Requests are handled one at a time. A request with zero
// size, an ignored op or an address below the base ends without a shadow
// walk. A check reads each granule through the registered RAM read before
// evaluating it, and a fill writes one granule per cycle.
// The result waits in an output register; a stalled receiver holds it there
// while the next request is accepted and worked on, and that request only
// waits for the register to free up before it completes.
// Depends on shmc_pkg, shmc_req_if, shmc_rsp_if, shmc_ctrl and shmc_datapath.
`default_nettype none

module shadow_memory_access_checker_core #(
    parameter int unsigned SHADOW_BYTES = shmc_pkg::SHADOW_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    shmc_req_if.sink         i_req,
    shmc_rsp_if.source       o_rsp
);

    shmc_pkg::t_cmd    cmd;
    shmc_pkg::t_status st;

    shmc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    shmc_datapath #(
        .SHADOW_BYTES (SHADOW_BYTES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_op           (i_req.op),
        .i_addr         (i_req.addr),
        .i_size         (i_req.size),
        .i_poison_value (i_req.poison_value),
        .i_wr_access    (i_req.wr_access),
        .i_cmd          (cmd),
        .o_st           (st),
        .o_fault        (o_rsp.fault),
        .o_fault_kind   (o_rsp.fault_kind),
        .o_report_addr  (o_rsp.report_addr),
        .o_report_size  (o_rsp.report_size),
        .o_report_write (o_rsp.report_write)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/shmc_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module shmc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/shmc_datapath.sv =====
// Datapath of the shadow memory access checker: request and base registers,
// granule arithmetic, the walk counter, the shadow RAM and the result register.
// Depends on shmc_pkg and shmc_ram.
`default_nettype none

module shmc_datapath #(
    parameter int unsigned SHADOW_BYTES = shmc_pkg::SHADOW_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [31:0]       i_cfg_wdata,
    input  wire logic [1:0]        i_op,
    input  wire logic [31:0]       i_addr,
    input  wire logic [23:0]       i_size,
    input  wire logic [7:0]        i_poison_value,
    input  wire logic              i_wr_access,
    input  wire shmc_pkg::t_cmd    i_cmd,
    output shmc_pkg::t_status      o_st,
    output logic                   o_fault,
    output logic [1:0]             o_fault_kind,
    output logic [31:0]            o_report_addr,
    output logic [23:0]            o_report_size,
    output logic                   o_report_write
);

    localparam int unsigned AW = $clog2(SHADOW_BYTES);
    localparam int unsigned CW = $clog2(SHADOW_BYTES + 1);
    localparam logic [29:0] NGRAN = 30'(SHADOW_BYTES);

    logic [31:0]       r_base;
    shmc_pkg::t_op     r_op;
    logic [31:0]       r_addr;
    logic [23:0]       r_size;
    logic [23:0]       r_size_m1;
    logic [7:0]        r_value;
    logic              r_write;
    logic [31:0]       r_rel;
    logic              r_below;
    logic [32:0]       r_end;
    logic [32:0]       r_last;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     r_stop;

    logic [29:0]       g_last;
    logic [29:0]       g_end;
    logic              partial;
    logic              win_bad;
    logic              at_stop;
    logic [7:0]        rd_data;
    logic [7:0]        wr_data;
    logic              bad_byte;

    assign g_last  = r_last[32:3];
    assign g_end   = r_end[32:3];
    assign partial = (r_op == shmc_pkg::OP_UNPOISON) && (r_size[2:0] != 3'd0);
    assign at_stop = (r_cnt == r_stop);

    // A check reads up to the last covered granule; a fill writes up to the end
    // granule, plus that granule itself when an unpoison leaves a partial marker.
    always_comb begin
        if (r_op == shmc_pkg::OP_CHECK) begin
            win_bad = (g_last >= NGRAN);
        end else if (partial) begin
            win_bad = (g_end >= NGRAN);
        end else begin
            win_bad = (g_end > NGRAN);
        end
    end

    always_comb begin
        if (at_stop) begin
            bad_byte = (rd_data != 8'd0) && ($signed(rd_data) <= $signed({5'd0, r_last[2:0]}));
        end else begin
            bad_byte = (rd_data != 8'd0);
        end
    end

    always_comb begin
        if (i_cmd.clr_sel) begin
            wr_data = 8'd0;
        end else if (at_stop) begin
            wr_data = {5'd0, r_size[2:0]};
        end else if (r_op == shmc_pkg::OP_POISON) begin
            wr_data = r_value;
        end else begin
            wr_data = 8'd0;
        end
    end

    assign o_st.op        = r_op;
    assign o_st.size_zero = (r_size == 24'd0);
    assign o_st.below     = r_below;
    assign o_st.win_bad   = win_bad;
    assign o_st.at_stop   = at_stop;
    assign o_st.bad_byte  = bad_byte;
    assign o_st.partial   = partial;
    assign o_st.clr_last  = (r_cnt == CW'(SHADOW_BYTES - 1));

    // Control registers: base address and the walk counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= shmc_pkg::BASE_RESET;
            r_cnt  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            if (i_cmd.calc_win) begin
                r_cnt <= r_rel[CW+2:3];
            end else if (i_cmd.step) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= shmc_pkg::t_op'(i_op);
            r_addr    <= i_addr;
            r_size    <= i_size;
            r_size_m1 <= i_size - 24'd1;
            r_value   <= i_poison_value;
            r_write   <= i_wr_access;
        end
        if (i_cmd.calc_rel) begin
            {r_below, r_rel} <= {1'b0, r_addr} - {1'b0, r_base};
        end
        if (i_cmd.calc_range) begin
            r_end  <= {1'b0, r_rel} + 33'(r_size);
            r_last <= {1'b0, r_rel} + 33'(r_size_m1);
        end
        if (i_cmd.calc_win) begin
            r_stop <= (r_op == shmc_pkg::OP_CHECK) ? r_last[CW+2:3] : r_end[CW+2:3];
        end
        if (i_cmd.out_load) begin
            o_fault      <= (i_cmd.kind != shmc_pkg::KIND_NONE);
            o_fault_kind <= i_cmd.kind;
            if (i_cmd.kind != shmc_pkg::KIND_NONE) begin
                o_report_addr  <= r_addr;
                o_report_size  <= r_size;
                o_report_write <= r_write;
            end else begin
                o_report_addr  <= 32'd0;
                o_report_size  <= 24'd0;
                o_report_write <= 1'b0;
            end
        end
    end

    shmc_ram #(
        .WIDTH (8),
        .DEPTH (SHADOW_BYTES)
    ) u_shadow (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_we),
        .i_addr  (r_cnt[AW-1:0]),
        .i_wdata (wr_data),
        .o_rdata (rd_data)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/shmc_ctrl.sv =====
// Controller of the shadow memory access checker: clearing pass, request
// sequencing, shadow walk and result hand-off. Depends on shmc_pkg.
`default_nettype none

module shmc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    input  wire shmc_pkg::t_status i_st,
    output shmc_pkg::t_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_RANGE,
        S_WIN,
        S_CHK_RD,
        S_CHK_EV,
        S_FILL,
        S_DONE
    } t_state;

    t_state          r_state;
    t_state          n_state;
    shmc_pkg::t_kind r_kind;
    shmc_pkg::t_kind n_kind;
    logic            r_out_valid;

    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.kind = r_kind;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.mem_we  = 1'b1;
                o_cmd.clr_sel = 1'b1;
                if (i_st.clr_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ADDR;
                end
            end
            S_ADDR: begin
                o_cmd.calc_rel = 1'b1;
                n_state        = S_RANGE;
            end
            S_RANGE: begin
                priority if (i_st.op == shmc_pkg::OP_IGNORE || i_st.size_zero) begin
                    n_kind  = shmc_pkg::KIND_NONE;
                    n_state = S_DONE;
                end else if (i_st.below) begin
                    n_kind  = shmc_pkg::KIND_BELOW;
                    n_state = S_DONE;
                end else begin
                    o_cmd.calc_range = 1'b1;
                    n_state          = S_WIN;
                end
            end
            S_WIN: begin
                o_cmd.calc_win = 1'b1;
                priority if (i_st.win_bad) begin
                    n_kind  = shmc_pkg::KIND_WINDOW;
                    n_state = S_DONE;
                end else if (i_st.op == shmc_pkg::OP_CHECK) begin
                    n_state = S_CHK_RD;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_CHK_RD: begin
                n_state = S_CHK_EV;
            end
            S_CHK_EV: begin
                priority if (i_st.bad_byte) begin
                    n_kind  = shmc_pkg::KIND_POISONED;
                    n_state = S_DONE;
                end else if (i_st.at_stop) begin
                    n_kind  = shmc_pkg::KIND_NONE;
                    n_state = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_CHK_RD;
                end
            end
            S_FILL: begin
                // The end granule is written only when it takes a partial marker.
                o_cmd.mem_we = !i_st.at_stop || i_st.partial;
                if (i_st.at_stop) begin
                    n_kind  = shmc_pkg::KIND_NONE;
                    n_state = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_kind      <= shmc_pkg::KIND_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_we_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mem_we |-> (r_state == S_CLEAR || r_state == S_FILL))
        else $error("shadow written outside clearing or fill");

    a_rise_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result raised without a finished request");

    a_poison_only_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_kind == shmc_pkg::KIND_POISONED)
            |-> i_st.op == shmc_pkg::OP_CHECK)
        else $error("poisoned fault reported for a fill request");

    a_fill_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FILL |-> !i_st.win_bad)
        else $error("fill running on a range outside the shadow window");

endmodule

`default_nettype wire
